FILE: hw/rtl/scc_pkg.sv
package scc_pkg;

    localparam int WORD_W     = 32;
    localparam int ROWS_W     = 31;
    localparam int COLS_W     = 11;
    localparam int STATUS_W   = 4;
    localparam int PTR_W      = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] WORD_NA = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 4'd0,
        ST_PTR_COUNT = 4'd1,
        ST_FIRST_NZ  = 4'd2,
        ST_PTR_NA    = 4'd3,
        ST_PTR_DEC   = 4'd4,
        ST_PTR_STEP  = 4'd5,
        ST_IDX_NA    = 4'd6,
        ST_IDX_RANGE = 4'd7,
        ST_IDX_DUP   = 4'd8,
        ST_TOO_FEW   = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR,
        S_CHK_FIN,
        S_CHK_COL,
        S_IDX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic                     last;
        logic                     na;
        logic                     neg;
    } t_item;

    typedef struct packed {
        logic [ROWS_W-1:0] num_rows;
        logic [COLS_W-1:0] num_cols;
    } t_cfg;

endpackage

FILE: hw/rtl/scc_ram.sv
module scc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/scc_front.sv
module scc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [scc_pkg::WORD_W-1:0] i_word,
    input  logic                          i_last,
    output logic                          o_q_valid,
    output scc_pkg::t_item                o_q_item,
    input  logic                          i_q_pop
);
    import scc_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;
    t_item      item;

    // classify the word on entry so the back end only looks at flags
    always_comb begin
        item.word = i_word;
        item.last = i_last;
        item.na   = (i_word == WORD_NA);
        item.neg  = i_word[WORD_W-1];
    end

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end
endmodule

FILE: hw/rtl/scc_back.sv
module scc_back #(
    parameter int MAX_COLS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scc_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_valid,
    input  scc_pkg::t_item                  i_q_item,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [scc_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_done_res,
    output logic                            o_sorted
);
    import scc_pkg::*;

    localparam int AW = $clog2(MAX_COLS + 1);
    localparam int CW = $clog2(MAX_COLS + 2);

    t_state                r_state, n_state;
    logic signed [WORD_W-1:0] r_word, n_word;
    logic                  r_last, n_last;
    logic                  r_na, n_na;
    logic                  r_neg, n_neg;
    logic [CW-1:0]         r_ptr_cnt, n_ptr_cnt;
    logic [AW-1:0]         r_col, n_col;
    logic [PTR_W-1:0]      r_idx_cnt, n_idx_cnt;
    logic signed [WORD_W-1:0] r_prev_row, n_prev_row;
    logic [PTR_W-1:0]      r_prev_ptr, n_prev_ptr;
    logic                  r_sorted, n_sorted;
    t_status               r_err, n_err;
    logic [PTR_W-1:0]      r_final, n_final;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic                  r_out_done, n_out_done;
    logic                  r_out_sorted, n_out_sorted;

    logic [31:0]           num_cols_ext;
    logic [AW-1:0]         ncols_eff;
    logic [CW-1:0]         need;
    logic                  ptr_phase;
    logic                  out_free;
    logic signed [WORD_W-1:0] prev_ptr_s;
    logic signed [WORD_W-1:0] rows_s;
    logic [PTR_W-1:0]      ptr_step;
    logic                  skip_col;
    t_status               err_fin;

    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [PTR_W-1:0]      ram_rdata;

    assign num_cols_ext = {21'b0, i_cfg.num_cols};
    assign ncols_eff    = (num_cols_ext > 32'(MAX_COLS)) ? AW'(MAX_COLS) : AW'(num_cols_ext);
    assign need         = CW'(ncols_eff) + CW'(1);
    assign ptr_phase    = (r_ptr_cnt < need);
    assign out_free     = !r_out_valid || i_out_ready;
    assign prev_ptr_s   = $signed({1'b0, r_prev_ptr});
    assign rows_s       = $signed({1'b0, i_cfg.num_rows});
    assign ptr_step     = r_word[PTR_W-1:0] - r_prev_ptr;
    assign skip_col     = (r_col < ncols_eff) && (r_idx_cnt >= ram_rdata);

    // end-of-record checks, applied only when nothing is held yet
    always_comb begin
        err_fin = r_err;
        if (r_last && (r_err == ST_OK)) begin
            if (ptr_phase) begin
                err_fin = ST_PTR_COUNT;
            end else if (r_idx_cnt < r_final) begin
                err_fin = ST_TOO_FEW;
            end
        end
    end

    scc_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_COLS + 1)
    ) u_ptr_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr_cnt[AW-1:0]),
        .i_wdata (r_word[PTR_W-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (r_err != ST_OK) begin
                        n_state = S_OUT;
                    end else if (ptr_phase) begin
                        n_state = S_PTR;
                    end else begin
                        n_state = S_CHK_FIN;
                    end
                end
            end
            S_PTR:     n_state = S_OUT;
            S_CHK_FIN: begin
                if (r_idx_cnt >= ram_rdata) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CHK_COL;
                end
            end
            S_CHK_COL: begin
                if (skip_col) begin
                    n_state = S_CHK_COL;
                end else begin
                    n_state = S_IDX;
                end
            end
            S_IDX:     n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = ncols_eff;
        case (r_state)
            S_IDLE:    o_q_pop = i_q_valid;
            S_PTR: begin
                if (r_ptr_cnt == '0) begin
                    ram_we = (r_word == '0);
                end else begin
                    ram_we = !r_na && !(r_word < prev_ptr_s) && !(ptr_step > i_cfg.num_rows);
                end
            end
            S_CHK_FIN: ram_raddr = r_col;
            S_CHK_COL: ram_raddr = r_col + AW'(1);
            S_IDX:     ram_raddr = ncols_eff;
            S_OUT:     ram_raddr = ncols_eff;
            default:   ram_raddr = ncols_eff;
        endcase
    end

    // datapath
    always_comb begin
        n_word       = r_word;
        n_last       = r_last;
        n_na         = r_na;
        n_neg        = r_neg;
        n_ptr_cnt    = r_ptr_cnt;
        n_col        = r_col;
        n_idx_cnt    = r_idx_cnt;
        n_prev_row   = r_prev_row;
        n_prev_ptr   = r_prev_ptr;
        n_sorted     = r_sorted;
        n_err        = r_err;
        n_final      = r_final;
        n_out_valid  = (r_out_valid && !i_out_ready);
        n_out_status = r_out_status;
        n_out_done   = r_out_done;
        n_out_sorted = r_out_sorted;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_word = i_q_item.word;
                    n_last = i_q_item.last;
                    n_na   = i_q_item.na;
                    n_neg  = i_q_item.neg;
                end
            end
            S_PTR: begin
                if (r_ptr_cnt == '0 && r_word != '0) begin
                    n_err = ST_FIRST_NZ;
                end else if (r_ptr_cnt != '0 && r_na) begin
                    n_err = ST_PTR_NA;
                end else if (r_ptr_cnt != '0 && (r_word < prev_ptr_s)) begin
                    n_err = ST_PTR_DEC;
                end else if (r_ptr_cnt != '0 && (ptr_step > i_cfg.num_rows)) begin
                    n_err = ST_PTR_STEP;
                end else begin
                    n_prev_ptr = r_word[PTR_W-1:0];
                    n_final    = r_word[PTR_W-1:0];
                    n_ptr_cnt  = r_ptr_cnt + CW'(1);
                end
            end
            S_CHK_FIN: n_final = ram_rdata;
            S_CHK_COL: begin
                // step past columns that end at or before this index
                if (skip_col) begin
                    n_col      = r_col + AW'(1);
                    n_prev_row = '1;
                end
            end
            S_IDX: begin
                if (r_na) begin
                    n_err = ST_IDX_NA;
                end else if (r_neg || (r_word >= rows_s)) begin
                    n_err = ST_IDX_RANGE;
                end else if (r_word == r_prev_row) begin
                    n_err = ST_IDX_DUP;
                end else begin
                    if (r_word < r_prev_row) begin
                        n_sorted = 1'b0;
                    end
                    n_prev_row = r_word;
                    n_idx_cnt  = r_idx_cnt + PTR_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = err_fin;
                    n_out_done   = (err_fin != ST_OK) || r_last;
                    n_out_sorted = r_sorted;
                    n_err        = err_fin;
                    if (r_last) begin
                        n_ptr_cnt  = '0;
                        n_col      = AW'(1);
                        n_idx_cnt  = '0;
                        n_prev_row = '1;
                        n_prev_ptr = '0;
                        n_sorted   = 1'b1;
                        n_err      = ST_OK;
                    end
                end
            end
            default: n_err = r_err;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr_cnt   <= '0;
            r_col       <= AW'(1);
            r_idx_cnt   <= '0;
            r_prev_row  <= '1;
            r_prev_ptr  <= '0;
            r_sorted    <= 1'b1;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr_cnt   <= n_ptr_cnt;
            r_col       <= n_col;
            r_idx_cnt   <= n_idx_cnt;
            r_prev_row  <= n_prev_row;
            r_prev_ptr  <= n_prev_ptr;
            r_sorted    <= n_sorted;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_word       <= n_word;
        r_last       <= n_last;
        r_na         <= n_na;
        r_neg        <= n_neg;
        r_final      <= n_final;
        r_out_status <= n_out_status;
        r_out_done   <= n_out_done;
        r_out_sorted <= n_out_sorted;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_done_res  = r_out_done;
    assign o_sorted    = r_out_sorted;
endmodule

FILE: hw/rtl/sparse_column_structure_checker_top.sv
// Checks one compressed-sparse-column record per stream of words: the first
// min(num_cols, MAX_COLS)+1 words are column pointers, the rest row indices,
// and each accepted word yields one status transaction (status, done_res,
// sorted). A two-entry front queue takes words while the back-end sequencer
// works, and the output register lets the next word in while a result waits.
// The back end handles one word at a time: a pointer word goes IDLE-PTR-OUT;
// a row index IDLE-CHK_FIN-CHK_COL-IDX-OUT with CHK_COL again per empty column
// skipped (one read each of the pointer memory's single registered read port);
// an index beyond the final pointer IDLE-CHK_FIN-OUT; any word after an error
// IDLE-OUT. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data
// (index 0 num_rows, index 1 num_cols) and applies from the next word on.
module sparse_column_structure_checker_top #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [scc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [scc_pkg::WORD_W-1:0]    i_word,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [scc_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_done_res,
    output logic                                 o_sorted
);
    import scc_pkg::*;

    logic [ROWS_W-1:0] r_num_rows;
    logic [COLS_W-1:0] r_num_cols;
    t_cfg              cfg;
    logic              q_valid;
    t_item             q_item;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= '0;
            r_num_cols <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_NUM_COLS: r_num_cols <= i_cfg_data[COLS_W-1:0];
                default:      r_num_rows <= r_num_rows;
            endcase
        end
    end

    assign cfg.num_rows = r_num_rows;
    assign cfg.num_cols = r_num_cols;

    scc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_word     (i_word),
        .i_last     (i_last),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    scc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_done_res  (o_done_res),
        .o_sorted    (o_sorted)
    );
endmodule
